/* rtl/wfha_pkg.sv */
`timescale 1ns / 1ps

package wfha_pkg;

  // operation codes carried on s_tuser
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // status codes carried on m_tuser
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam int REQ_W   = 12;
  localparam int ADDR_W  = 12;
  localparam int LIMIT_W = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] payload_address;
  } wfha_res_t;

endpackage

/* rtl/worst_fit_heap_allocator.sv */
`timescale 1ns / 1ps

// Worst-fit allocator over an arena of ARENA_BYTES bytes kept as an implicit list of
// HEADER_BYTES-byte headers in a header RAM with one read and one write port. One request
// is in work at a time and each gives one result transfer. An allocate walks the list from
// offset 0, one header per cycle through the RAM read port, over the N headers below the
// arena top (at most ARENA_BYTES / HEADER_BYTES), and writes one more header when the
// remainder of the chosen block is split off. A free reads the header and writes it back as
// unused. The result sits in an output register, so the next request may be taken while it
// waits. heap_limit is written on the cfg channel, which is always ready, and is to be
// changed only while no request is in work.

module worst_fit_heap_allocator
  import wfha_pkg::*;
#(
  parameter int ARENA_BYTES  = 4096,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // request_bytes [11:0], address [23:12]
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // payload_address [11:0], zero [15:12]
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data   // heap_limit
);

  localparam int AW = $clog2(ARENA_BYTES);

  logic [LIMIT_W-1:0] heap_limit;
  logic               res_valid;
  logic               res_ready;
  wfha_res_t          res;
  logic [AW-1:0]      ram_raddr;
  logic [AW:0]        ram_rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW:0]        ram_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      heap_limit <= cfg_data;
    end
  end

  wfha_ctrl #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (s_tuser),
    .in_req     (s_tdata[11:0]),
    .in_addr    (s_tdata[23:12]),
    .heap_limit (heap_limit),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  wfha_hdr_ram #(
    .DEPTH (ARENA_BYTES),
    .AW    (AW),
    .DW    (AW + 1)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: loads when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {4'b0000, res.payload_address};
      m_tuser <= res.status;
    end
  end

endmodule

/* rtl/wfha_hdr_ram.sv */
`timescale 1ns / 1ps

module wfha_hdr_ram #(
  parameter int DEPTH  = 4096,
  parameter int AW     = 12,
  parameter int DW     = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/wfha_ctrl.sv */
`timescale 1ns / 1ps

module wfha_ctrl
  import wfha_pkg::*;
#(
  parameter int ARENA_BYTES  = 4096,
  parameter int HEADER_BYTES = 16,
  localparam int AW = $clog2(ARENA_BYTES)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [REQ_W-1:0]   in_req,
  input  logic [ADDR_W-1:0]  in_addr,
  input  logic [LIMIT_W-1:0] heap_limit,
  output logic               res_valid,
  input  logic               res_ready,
  output wfha_res_t          res,
  output logic [AW-1:0]      ram_raddr,
  input  logic [AW:0]        ram_rdata,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [AW:0]        ram_wdata
);

  // working width for offsets, sizes and sums of them
  localparam int WW = ((AW > REQ_W) ? AW : REQ_W) + 2;
  localparam logic [WW-1:0] HDR   = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] ARENA = WW'(ARENA_BYTES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_FRD    = 3'd2;
  localparam logic [2:0] S_FWR    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_SPLIT  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state;
  logic [AW:0]       top;
  logic [REQ_W-1:0]  req;
  logic [WW-1:0]     cur;
  logic [WW-1:0]     best;
  logic [WW-1:0]     best_size;
  logic              found;
  logic [1:0]        res_status;
  logic [ADDR_W-1:0] res_addr;

  logic          rd_used;
  logic [WW-1:0] rd_size;
  logic [WW-1:0] req_w;
  logic [WW-1:0] top_w;
  logic [WW-1:0] nxt;
  logic          take;
  logic          walk_more;
  logic [WW-1:0] lim_w;
  logic [WW-1:0] new_top;
  logic          grow_fail;
  logic          do_split;
  logic [WW-1:0] split_off;
  logic [WW-1:0] split_size;
  logic [WW-1:0] best_pay;
  logic [WW-1:0] top_pay;
  logic [WW-1:0] in_a_w;

  always_comb begin
    rd_used    = ram_rdata[AW];
    rd_size    = WW'(ram_rdata[AW-1:0]);
    req_w      = WW'(req);
    top_w      = WW'(top);
    nxt        = cur + HDR + rd_size;
    take       = !rd_used && (rd_size >= req_w) && (!found || (rd_size > best_size));
    walk_more  = (nxt < top_w) && (nxt < ARENA);
    lim_w      = (WW'(heap_limit) < ARENA) ? WW'(heap_limit) : ARENA;
    new_top    = top_w + HDR + req_w;
    grow_fail  = (new_top > lim_w) || (top_w + HDR >= ARENA);
    do_split   = best_size > req_w + HDR;
    split_off  = best + HDR + req_w;
    split_size = best_size - req_w - HDR;
    best_pay   = best + HDR;
    top_pay    = top_w + HDR;
    in_a_w     = WW'(in_addr);
  end

  // one header read per cycle: the next read address comes straight from the header just read
  always_comb begin
    case (state)
      S_IDLE:  ram_raddr = '0;
      S_WALK:  ram_raddr = nxt[AW-1:0];
      default: ram_raddr = cur[AW-1:0];
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best[AW-1:0];
    ram_wdata = {1'b1, best_size[AW-1:0]};
    case (state)
      S_FWR: begin
        ram_we    = 1'b1;
        ram_waddr = cur[AW-1:0];
        ram_wdata = {1'b0, ram_rdata[AW-1:0]};
      end
      S_DECIDE: begin
        if (found) begin
          ram_we = 1'b1;
          if (do_split) begin
            // remainder header first, the granted header follows in S_SPLIT
            ram_waddr = split_off[AW-1:0];
            ram_wdata = {1'b0, split_size[AW-1:0]};
          end
        end else if (!grow_fail) begin
          ram_we    = 1'b1;
          ram_waddr = top[AW-1:0];
          ram_wdata = {1'b1, req_w[AW-1:0]};
        end
      end
      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, req_w[AW-1:0]};
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      top   <= '0;
      found <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req      <= in_req;
            found    <= 1'b0;
            cur      <= '0;
            res_addr <= '0;
            case (in_op)
              OP_ALLOC: begin
                state <= (top == '0) ? S_DECIDE : S_WALK;
              end
              OP_FREE: begin
                if (in_a_w < HDR || in_a_w >= top_w) begin
                  res_status <= ST_INVALID;
                  state      <= S_DONE;
                end else begin
                  cur        <= in_a_w - HDR;
                  res_status <= ST_OK;
                  state      <= S_FRD;
                end
              end
              OP_RELEASE: begin
                top        <= '0;
                res_status <= ST_OK;
                state      <= S_DONE;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_WALK: begin
          if (take) begin
            found     <= 1'b1;
            best      <= cur;
            best_size <= rd_size;
          end
          if (walk_more) begin
            cur <= nxt;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_FRD: state <= S_FWR;
        S_FWR: state <= S_DONE;
        S_DECIDE: begin
          if (found) begin
            res_status <= ST_OK;
            res_addr   <= best_pay[ADDR_W-1:0];
            state      <= do_split ? S_SPLIT : S_DONE;
          end else if (grow_fail) begin
            res_status <= ST_OOM;
            res_addr   <= '0;
            state      <= S_DONE;
          end else begin
            top        <= new_top[AW:0];
            res_status <= ST_OK;
            res_addr   <= top_pay[ADDR_W-1:0];
            state      <= S_DONE;
          end
        end
        S_SPLIT: state <= S_DONE;
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready            = (state == S_IDLE);
  assign res_valid           = (state == S_DONE);
  assign res.status          = res_status;
  assign res.payload_address = res_addr;

endmodule

/* rtl/wfha_checker.sv */
`timescale 1ns / 1ps

module wfha_checker
  import wfha_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // failed requests never grant an address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == 16'd0)
    else $error("failure carries a nonzero address");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind worst_fit_heap_allocator wfha_checker u_wfha_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
